// ----- rtl/core/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types for the stack with middle access: operation and status codes,
// and the control word broadcast to every storage cell.
// ----------------------------------------------------------------------------
package swm_pkg;

   // Operation codes carried on the request word
   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_DELETE = 2'd3
   } func_type;

   // Completion codes carried on the response word
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Per-cycle command broadcast along the cell chain
   typedef struct packed {
      logic push;    // write push data into the cell at the current count
      logic del;     // close the gap: cells from mid up take their upper neighbor
   } cell_ctl_type;

endpackage

// ----- rtl/core/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell
// One storage slot of the stack. Loads push data when it is the next free
// slot, takes its upper neighbor's value during a middle delete, and drives
// its value onto the read bus when its index is selected.
// ----------------------------------------------------------------------------
module swm_cell
   import swm_pkg::*;
#(
   parameter int CW    = 5,
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [CW-1:0]      count,
   input  logic [CW-1:0]      mid,
   input  logic [IW-1:0]      rd_idx,
   input  logic signed [31:0] push_value,
   input  logic signed [31:0] upper_value,
   output logic signed [31:0] value,
   output logic signed [31:0] rd_part
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               at_top;
   logic               in_shift;

   // Position of this cell relative to the live region
   assign at_top   = (CW'(INDEX) == count);
   assign in_shift = (CW'(INDEX) >= mid) && (CW'(INDEX + 1) < count);

   // Next value
   always_comb begin
      value_in = value_ff;
      if (ctl.push && at_top) begin
         value_in = push_value;
      end else if (ctl.del && in_shift) begin
         value_in = upper_value;
      end
   end

   // Slot storage; content undefined until first written
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value   = value_ff;
   assign rd_part = (IW'(INDEX) == rd_idx) ? value_ff : 32'sd0;

endmodule

// ----- rtl/core/stack_with_middle_access.sv -----
// ----------------------------------------------------------------------------
// stack_with_middle_access
// Bounded LIFO stack with read and delete of the middle entry (index
// (n-1)/2 from the bottom), built as a chain of storage cells.
// ----------------------------------------------------------------------------
// Response valid rises in the cycle after a request is accepted.
// Throughput: one word per cycle unless the response side stalls; every
// cell updates in parallel for push, pop and middle delete.
// Reset clears the entry count and the response valid; slot contents stay
// undefined until pushed.
// ----------------------------------------------------------------------------
module stack_with_middle_access
   import swm_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_entry_count
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      cnt_m1;
   logic [CW-1:0]      mid_full;
   logic [IW-1:0]      rd_idx;
   logic               rd_sel;
   logic               accept;
   status_type         status;
   cell_ctl_type       ctl;
   logic signed [31:0] rd_or;
   logic [CW+4:0]      count_ext;

   logic signed [31:0] cell_value [DEPTH];
   logic signed [31:0] cell_rd    [DEPTH];

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_read_value_ff;
   status_type         rsp_status_ff;
   logic [4:0]         rsp_count_ff;

   // Handshake: the response register frees up when its word is taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Top and middle positions of the live region
   assign cnt_m1   = count_ff - CW'(1);
   assign mid_full = cnt_m1 >> 1;

   // Operation decode
   always_comb begin
      count_in = count_ff;
      status   = ST_DONE;
      rd_sel   = 1'b0;
      rd_idx   = mid_full[IW-1:0];
      ctl      = '0;
      unique case (func_type'(req_func))
         FUNC_PUSH: begin
            if (count_ff == CW'(DEPTH)) begin
               status = ST_FULL;
            end else begin
               ctl.push = accept;
               count_in = count_ff + CW'(1);
            end
         end
         FUNC_POP: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               rd_idx   = cnt_m1[IW-1:0];
               rd_sel   = 1'b1;
               count_in = cnt_m1;
            end
         end
         FUNC_READ: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               rd_sel = 1'b1;
            end
         end
         FUNC_DELETE: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               ctl.del  = accept;
               rd_sel   = 1'b1;
               count_in = cnt_m1;
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   // Cell chain; the last cell has no upper neighbor and never shifts
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] upper;
      if (i == DEPTH - 1) begin : g_last
         assign upper = cell_value[i];
      end else begin : g_mid
         assign upper = cell_value[i+1];
      end
      swm_cell #(
         .CW    (CW),
         .IW    (IW),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .mid         (mid_full),
         .rd_idx      (rd_idx),
         .push_value  (req_push_value),
         .upper_value (upper),
         .value       (cell_value[i]),
         .rd_part     (cell_rd[i])
      );
   end

   // Read bus: only the selected cell drives a nonzero value
   always_comb begin
      rd_or = 32'sd0;
      for (int k = 0; k < DEPTH; k++) begin
         rd_or = rd_or | cell_rd[k];
      end
   end

   // Entry count reported modulo 32
   assign count_ext = {5'd0, count_in};

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff <= rd_sel ? rd_or : 32'sd0;
         rsp_status_ff     <= status;
         rsp_count_ff      <= count_ext[4:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_func == FUNC_PUSH) && (count_ff != CW'(DEPTH))
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not grow the stack");

   a_refuse_holds: assert property (@(posedge clock) disable iff (reset)
      accept && (status != ST_DONE) |=> $stable(count_ff))
      else $error("refused request changed the count");

   a_full_only_at_depth: assert property (@(posedge clock) disable iff (reset)
      accept && (status == ST_FULL) |-> count_ff == CW'(DEPTH))
      else $error("full refusal below depth");

endmodule

// ----- test/tb_stack_with_middle_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_with_middle_access
// Self-checking bench for the stack with middle access. A shadow stack
// predicts every response word from each accepted request. A checker
// compares the response words field by field, in order, against the
// predictions. Stimulus covers refusals when empty and full, the
// single-entry cases, middle read and delete at even and odd counts, a long
// output hold-off, and random push/pop walks. Both sides idle at random except in quiet mode.
// ----------------------------------------------------------------------------
module tb_stack_with_middle_access;
   import swm_pkg::*;

   localparam int STACK_DEPTH = 16;
   localparam int IDLE_PCT    = 10;
   localparam int SHOW_LIMIT  = 10;

   // One predicted response word
   typedef struct {
      logic signed [31:0] read_value;
      status_type         status;
      logic [4:0]         entry_count;
   } stack_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = FUNC_PUSH;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_entry_count;

   // Shadow copy of the stack
   logic [31:0]        shadow_slots [STACK_DEPTH];
   int                 shadow_depth = 0;

   stack_reply_type    pending_replies [$];
   int                 mismatch_count = 0;

   // Shared knobs for the idling processes
   bit                 quiet_mode = 1'b0;
   int                 hold_request = 0;
   int                 hold_left = 0;

   stack_with_middle_access #(
      .DEPTH(STACK_DEPTH)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   always #1 clock = ~clock;

   // Apply one operation to the shadow stack and return the expected word
   function automatic stack_reply_type stack_apply(func_type f, logic [31:0] value);
      stack_reply_type r;
      int              mid;
      r.read_value = '0;
      r.status     = ST_DONE;
      if (f == FUNC_PUSH) begin
         if (shadow_depth >= STACK_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            shadow_slots[shadow_depth] = value;
            shadow_depth++;
         end
      end else if (shadow_depth == 0) begin
         r.status = ST_EMPTY;
      end else if (f == FUNC_POP) begin
         shadow_depth--;
         r.read_value = shadow_slots[shadow_depth];
      end else begin
         mid = (shadow_depth - 1) / 2;
         r.read_value = shadow_slots[mid];
         if (f == FUNC_DELETE) begin
            for (int i = mid; i + 1 < shadow_depth; i++)
               shadow_slots[i] = shadow_slots[i + 1];
            shadow_depth--;
         end
      end
      r.entry_count = shadow_depth[4:0];
      return r;
   endfunction

   // Count a mismatch, showing only the first few
   task automatic note_mismatch(string what, stack_reply_type e);
      mismatch_count++;
      if (mismatch_count <= SHOW_LIMIT) begin
         $display("%0t mismatch (%s): exp value=%h status=%0d count=%0d",
                  $realtime, what, e.read_value, e.status, e.entry_count);
         $display("   got value=%h status=%0d count=%0d",
                  rsp_read_value, rsp_status, rsp_entry_count);
      end
   endtask

   // Predict accepted requests, then check accepted responses
   always @(posedge clock) begin
      stack_reply_type e;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_replies.push_back(stack_apply(func_type'(req_func), req_push_value));
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               e.read_value  = '0;
               e.status      = ST_DONE;
               e.entry_count = '0;
               note_mismatch("unexpected word", e);
            end else begin
               e = pending_replies.pop_front();
               if (rsp_read_value !== e.read_value)
                  note_mismatch("read_value", e);
               else if (rsp_status !== e.status)
                  note_mismatch("status", e);
               else if (rsp_entry_count !== e.entry_count)
                  note_mismatch("entry_count", e);
            end
         end
      end
   end

   // Output side: random stalls, a counted hold-off on request, none in quiet mode
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Offer one request word and hold it until accepted
   task automatic send_word(func_type f, logic [31:0] value);
      if (!quiet_mode) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Mostly random values, now and then a corner value
   function automatic logic [31:0] pick_value();
      case ($urandom_range(15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Push with the given weight in percent, otherwise one of the other three
   function automatic func_type pick_func(int push_pct);
      if ($urandom_range(99) < push_pct)
         return FUNC_PUSH;
      case ($urandom_range(2))
         0: return FUNC_POP;
         1: return FUNC_READ;
         default: return FUNC_DELETE;
      endcase
   endfunction

   // Every non-push operation on an empty stack is refused
   task automatic test_empty_refusals();
      send_word(FUNC_POP, $urandom);
      send_word(FUNC_READ, $urandom);
      send_word(FUNC_DELETE, $urandom);
   endtask

   // One entry: read, pop of the last entry, delete of the only entry
   task automatic test_single_entry();
      send_word(FUNC_PUSH, 32'h8000_0000);
      send_word(FUNC_READ, $urandom);
      send_word(FUNC_POP, $urandom);
      send_word(FUNC_PUSH, 32'h7FFF_FFFF);
      send_word(FUNC_DELETE, $urandom);
   endtask

   // Fill to the top, then push once more to get the full refusal
   task automatic test_fill_and_full();
      send_word(FUNC_PUSH, 32'hFFFF_FFFF);
      send_word(FUNC_PUSH, 32'h0000_0000);
      for (int i = 2; i < STACK_DEPTH; i++)
         send_word(FUNC_PUSH, 32'h1000_0000 + i);
      send_word(FUNC_PUSH, 32'h5555_AAAA);
   endtask

   // Middle read and delete at an even count, then at an odd count
   task automatic test_middle_ops();
      send_word(FUNC_READ, $urandom);
      send_word(FUNC_DELETE, $urandom);
      send_word(FUNC_READ, $urandom);
      send_word(FUNC_DELETE, $urandom);
   endtask

   // Output held off while requests keep coming, so the input stalls
   task automatic test_backpressure(int hold_cycles, int n_words);
      hold_request = hold_cycles;
      for (int i = 0; i < n_words; i++)
         send_word(pick_func(60), pick_value());
   endtask

   // Random walk alternating between filling and draining stretches
   task automatic test_random_walk(int n_words);
      int push_pct;
      for (int i = 0; i < n_words; i++) begin
         push_pct = ((i / 48) % 2 == 0) ? 75 : 25;
         send_word(pick_func(push_pct), pick_value());
      end
   endtask

   // Same walk with no idling on either side
   task automatic test_back_to_back(int n_words);
      quiet_mode = 1'b1;
      test_random_walk(n_words);
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_refusals();
      test_single_entry();
      test_fill_and_full();
      test_middle_ops();
      test_backpressure(80, 40);
      test_random_walk(850);
      test_back_to_back(150);

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin
      #200000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/stack_with_middle_access.sv
test/tb_stack_with_middle_access.sv
